// ----- rtl/sha1h_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_pkg
// Types, constants and round functions shared by the SHA-1 hasher modules.
// ----------------------------------------------------------------------------
package sha1h_pkg;

  // one queued item: a byte (when byte_valid) and the end-of-message mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } byte_item_t;

  typedef logic [31:0] word_t;

  localparam int unsigned N_ROUNDS = 80;
  localparam int unsigned N_CHAIN  = 5;

  // initial chaining values H0..H4
  localparam word_t H_INIT [N_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // round constants, one per group of twenty rounds
  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // round constant for round index rnd
  function automatic word_t round_k(input logic [6:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = K_0;
    end else if (rnd < 7'd40) begin
      k = K_1;
    end else if (rnd < 7'd60) begin
      k = K_2;
    end else begin
      k = K_3;
    end
    return k;
  endfunction

  // boolean function for round index rnd
  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ----- rtl/sha1h_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------

// message byte channel
interface sha1h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

// digest word channel
interface sha1h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

// ----- rtl/sha1h_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_front
// Accepts input items, drops items that carry neither byte nor end mark, and
// queues the rest for the hashing engine.
// ----------------------------------------------------------------------------
module sha1h_front
  import sha1h_pkg::*;
#(
  parameter int DEPTH = 4  // queue entries, at least 2
) (
  input  logic             clk,
  input  logic             rst_n,
  sha1h_in_if.sink         in_ch,
  output logic             q_valid,
  output byte_item_t       q_item,
  input  logic             q_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  byte_item_t          mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       level_r, level_nxt;
  logic                push;
  byte_item_t          in_item;

  // classify: only items with a byte or an end mark do any work
  assign in_item = '{data_byte: in_ch.data_byte, byte_valid: in_ch.byte_valid,
                     end_of_message: in_ch.end_of_message};
  assign in_ch.ready = (level_r != CW'(DEPTH));
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_valid || in_ch.end_of_message);

  assign q_valid = (level_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (!push && q_pop) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ----- rtl/sha1h_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_back
// Hashing engine: packs bytes into the message schedule, pads, runs the
// 80 compression rounds one per cycle and hands out the digest words.
// ----------------------------------------------------------------------------
module sha1h_back
  import sha1h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  byte_item_t  q_item,
  output logic        q_pop,
  sha1h_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_ADD, S_OUT} state_t;

  state_t       state_r, state_nxt;
  word_t        chain_r [N_CHAIN];
  word_t        chain_nxt [N_CHAIN];
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  count_r, count_nxt;
  logic [6:0]   round_r, round_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         pad_act_r, pad_act_nxt;
  logic         pad_first_r, pad_first_nxt;
  logic         len_r, len_nxt;
  logic         pad_done_r, pad_done_nxt;
  logic         out_valid_r, out_valid_nxt;
  word_t        out_word_r, out_word_nxt;
  logic         out_last_r, out_last_nxt;

  // schedule shift line and working variables
  word_t        w_r [16];
  logic [23:0]  acc_r;
  word_t        a_r, b_r, c_r, d_r, e_r;

  logic         put_en;
  logic [7:0]   put_val;
  logic         rnd_en;
  logic         ld_vars;
  logic         is_len;
  logic [63:0]  len_sh;
  word_t        w_mix, w_new, t_sum;

  // length byte for the current fill position (big-endian bit count)
  assign len_sh = {count_r, 3'b000} << {fill_r[2:0], 3'b000};
  assign is_len = len_r || (!pad_first_r && (fill_r == 6'd56));

  // next schedule word and round sum
  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + round_f(round_r, b_r, c_r, d_r) + e_r
                 + round_k(round_r) + w_r[0];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.last_word   = out_last_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    count_nxt     = count_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    pad_act_nxt   = pad_act_r;
    pad_first_nxt = pad_first_r;
    len_nxt       = len_r;
    pad_done_nxt  = pad_done_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    put_en        = 1'b0;
    put_val       = 8'h00;
    rnd_en        = 1'b0;
    ld_vars       = 1'b0;
    q_pop         = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.byte_valid) begin
            put_en    = 1'b1;
            put_val   = q_item.data_byte;
            count_nxt = count_r + 1'b1;
          end
          if (q_item.end_of_message) begin
            pad_act_nxt   = 1'b1;
            pad_first_nxt = 1'b1;
            len_nxt       = 1'b0;
            pad_done_nxt  = 1'b0;
          end
          if (q_item.byte_valid && (fill_r == 6'd63)) begin
            state_nxt = S_ROUND;
            ld_vars   = 1'b1;
            round_nxt = '0;
          end else if (q_item.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        put_en        = 1'b1;
        put_val       = pad_first_r ? PAD_MARK : (is_len ? len_sh[63:56] : 8'h00);
        pad_first_nxt = 1'b0;
        if (is_len) begin
          len_nxt = 1'b1;
        end
        if (fill_r == 6'd63) begin
          state_nxt = S_ROUND;
          ld_vars   = 1'b1;
          round_nxt = '0;
          if (is_len) begin
            pad_done_nxt = 1'b1;
          end
        end
      end
      S_ROUND: begin
        rnd_en    = 1'b1;
        round_nxt = round_r + 1'b1;
        if (round_r == 7'(N_ROUNDS - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        if (pad_done_r) begin
          state_nxt = S_OUT;
          idx_nxt   = '0;
        end else if (pad_act_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        // load the next digest word once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_r[idx_r];
          out_last_nxt  = (idx_r == 3'(N_CHAIN - 1));
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == 3'(N_CHAIN - 1)) begin
            chain_nxt    = H_INIT;
            count_nxt    = '0;
            idx_nxt      = '0;
            pad_act_nxt  = 1'b0;
            pad_done_nxt = 1'b0;
            len_nxt      = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign fill_nxt = put_en ? fill_r + 1'b1 : fill_r;

  // state, counters, chaining values and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chain_r     <= H_INIT;
      fill_r      <= '0;
      count_r     <= '0;
      round_r     <= '0;
      idx_r       <= '0;
      pad_act_r   <= 1'b0;
      pad_first_r <= 1'b0;
      len_r       <= 1'b0;
      pad_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      pad_act_r   <= pad_act_nxt;
      pad_first_r <= pad_first_nxt;
      len_r       <= len_nxt;
      pad_done_r  <= pad_done_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  // schedule shift line: byte packing and in-round expansion
  always_ff @(posedge clk) begin
    if (put_en) begin
      if (fill_r[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[15] <= {acc_r, put_val};
      end else begin
        acc_r <= {acc_r[15:0], put_val};
      end
    end else if (rnd_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ld_vars) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (rnd_en) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

endmodule

// ----- rtl/sha1_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 digest of a byte stream, five digest words out per message.
// ----------------------------------------------------------------------------
// The hasher takes one message byte per item; an item with end_of_message
// set closes the message (it may carry no byte, which gives the empty
// message) and five digest words follow, H0 first, the fifth with last_word
// set. Items with neither byte nor end mark are taken and ignored. Every
// full 64-byte block is compressed in 80 rounds at one per cycle and then
// added into the chaining values. An end item adds the padding bytes (up
// to 72), one or two compressions and the hand-out of the five digest
// words. A queue of QUEUE_DEPTH items in front of the engine keeps taking
// input, until it is full, while a block compresses, and the output
// register lets the next message start while the last digest word waits
// to be taken.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher
  import sha1h_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  sha1h_in_if.sink    in_ch,
  sha1h_out_if.source out_ch
);

  logic       q_valid;
  logic       q_pop;
  byte_item_t q_item;

  // intake and queue
  sha1h_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // hashing engine
  sha1h_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  // engine never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  // a full queue cannot look empty to the engine
  a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with nothing queued");

  // digest words go out back to back once one is taken
  a_digest_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_word) |=> out_ch.valid)
    else $error("gap inside a digest burst");
`endif

endmodule
